FILE: rtl/prm_pkg.sv
// package for the palette colour remap block: table size, op codes and beat types
// no dependencies; used by the interfaces, the table cell and the top level

package prm_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W = 4;
  localparam int unsigned CH_W = 8;
  localparam int unsigned CELL_ID_W =
      ($clog2(TABLE_ENTRIES) > IDX_W) ? $clog2(TABLE_ENTRIES) : IDX_W;

  typedef enum logic [1:0] {
    OP_PIXEL     = 2'd0,
    OP_WR_SOURCE = 2'd1,
    OP_WR_REPL   = 2'd2,
    OP_UNUSED    = 2'd3
  } op_e;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
    logic [CH_W-1:0] a;
  } rgba_t;

  // one beat travelling down the chain of cells
  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] entry_index;
    rgba_t            pix;
    logic             hit;
    logic [IDX_W-1:0] hit_entry;
  } token_t;

endpackage

FILE: rtl/prm_in_if.sv
// input channel of the palette colour remap block: valid/ready plus pixel or table write
// depends on prm_pkg

interface prm_in_if;
  import prm_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       op;
  logic [IDX_W-1:0] entry_index;
  logic [CH_W-1:0]  red_in;
  logic [CH_W-1:0]  green_in;
  logic [CH_W-1:0]  blue_in;
  logic [CH_W-1:0]  alpha_in;

  modport source (output valid, op, entry_index, red_in, green_in, blue_in, alpha_in,
                  input ready);
  modport sink (input valid, op, entry_index, red_in, green_in, blue_in, alpha_in,
                output ready);
endinterface

FILE: rtl/prm_out_if.sv
// output channel of the palette colour remap block: valid/ready plus remapped pixel
// depends on prm_pkg

interface prm_out_if;
  import prm_pkg::*;

  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  red_out;
  logic [CH_W-1:0]  green_out;
  logic [CH_W-1:0]  blue_out;
  logic [CH_W-1:0]  alpha_out;
  logic             was_replaced;
  logic [IDX_W-1:0] hit_entry;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, was_replaced,
                  hit_entry, input ready);
  modport sink (input valid, red_out, green_out, blue_out, alpha_out, was_replaced,
                hit_entry, output ready);
endinterface

FILE: rtl/prm_cell.sv
// one table cell: holds one source/replacement entry and one pipeline slot of the chain
// depends on prm_pkg

module prm_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  logic [prm_pkg::CELL_ID_W-1:0]  cell_id_i,
  input  logic                           valid_i,
  input  prm_pkg::token_t                tok_i,
  output logic                           valid_o,
  output prm_pkg::token_t                tok_o
);
  import prm_pkg::*;

  rgba_t  src_q, src_d;
  rgba_t  rep_q, rep_d;
  logic   valid_q, valid_d;
  token_t tok_q, tok_d;
  logic   id_match;
  logic   active;
  logic   match;

  assign id_match = (CELL_ID_W'(tok_i.entry_index) == cell_id_i);
  assign active   = (src_q != rep_q);
  assign match    = valid_i && (tok_i.op == OP_PIXEL) && !tok_i.hit && active &&
                    (src_q == tok_i.pix);

  always_comb begin
    src_d   = src_q;
    rep_d   = rep_q;
    valid_d = valid_q;
    tok_d   = tok_q;
    if (adv_i) begin
      valid_d = valid_i;
      tok_d   = tok_i;
      if (valid_i && id_match && (tok_i.op == OP_WR_SOURCE)) begin
        src_d = tok_i.pix;
      end
      if (valid_i && id_match && (tok_i.op == OP_WR_REPL)) begin
        rep_d = tok_i.pix;
      end
      // first active hit wins, alpha passes through
      if (match) begin
        tok_d.hit       = 1'b1;
        tok_d.hit_entry = IDX_W'(cell_id_i);
        tok_d.pix.r     = rep_q.r;
        tok_d.pix.g     = rep_q.g;
        tok_d.pix.b     = rep_q.b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q   <= '0;
      rep_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      src_q   <= src_d;
      rep_q   <= rep_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;

`ifndef ASSERT_OFF
  a_hit_only_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && tok_q.hit) |-> (tok_q.op == OP_PIXEL))
    else $error("hit flag set on a non-pixel beat");

  a_src_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && valid_i && id_match && (tok_i.op == OP_WR_SOURCE)) |=>
      (src_q == $past(tok_i.pix)))
    else $error("source entry write lost");
`endif

endmodule

FILE: rtl/palette_colour_remap_core.sv
// Palette colour remap: each RGBA8888 pixel is checked against a table of TABLE_ENTRIES
// entries; the lowest active entry whose source equals the pixel replaces its R, G and B,
// alpha always passes. Table writes (op 1 source, op 2 replacement) are beats on the same
// input channel and take effect in order with the pixels around them. The table is a chain
// of cells, one entry per cell; a beat moves one cell per cycle while the chain advances,
// passing each cell's register and then the output register. One beat is taken per cycle
// while the output is drained; a stall at the output holds the whole chain. Writes, op 3
// and writes past the table give no output beat. After reset the table is all zero.
// depends on prm_pkg, prm_in_if, prm_out_if, prm_cell

module palette_colour_remap_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  prm_in_if.sink        in_i,
  prm_out_if.source     out_o
);
  import prm_pkg::*;

  logic   adv;
  logic   vld [TABLE_ENTRIES+1];
  token_t tok [TABLE_ENTRIES+1];

  logic   out_valid_q, out_valid_d;
  token_t out_tok_q, out_tok_d;

  // chain moves unless a finished beat is stuck at the output
  assign adv        = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  assign vld[0]             = in_i.valid;
  assign tok[0].op          = op_e'(in_i.op);
  assign tok[0].entry_index = in_i.entry_index;
  assign tok[0].pix.r       = in_i.red_in;
  assign tok[0].pix.g       = in_i.green_in;
  assign tok[0].pix.b       = in_i.blue_in;
  assign tok[0].pix.a       = in_i.alpha_in;
  assign tok[0].hit         = 1'b0;
  assign tok[0].hit_entry   = '0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    prm_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .cell_id_i (CELL_ID_W'(g)),
      .valid_i   (vld[g]),
      .tok_i     (tok[g]),
      .valid_o   (vld[g+1]),
      .tok_o     (tok[g+1])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_tok_d   = out_tok_q;
    if (adv) begin
      out_valid_d = vld[TABLE_ENTRIES] && (tok[TABLE_ENTRIES].op == OP_PIXEL);
      out_tok_d   = tok[TABLE_ENTRIES];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_tok_q <= out_tok_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.red_out      = out_tok_q.pix.r;
  assign out_o.green_out    = out_tok_q.pix.g;
  assign out_o.blue_out     = out_tok_q.pix.b;
  assign out_o.alpha_out    = out_tok_q.pix.a;
  assign out_o.was_replaced = out_tok_q.hit;
  assign out_o.hit_entry    = out_tok_q.hit_entry;

`ifndef ASSERT_OFF
  a_no_hit_zero_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_tok_q.hit) |-> (out_tok_q.hit_entry == '0))
    else $error("hit_entry nonzero without a replacement");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with an empty output stage");
`endif

endmodule

FILE: verif/testbench.sv
// self-checking testbench for palette_colour_remap_core: table writes and pixels in random order
// depends on prm_pkg, prm_in_if, prm_out_if and the palette_colour_remap_core rtl

module testbench;
  import prm_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CHAIN_LATENCY = TABLE_ENTRIES + 1;

  typedef struct packed {
    rgba_t            pix;
    logic             replaced;
    logic [IDX_W-1:0] hit;
  } remap_result_t;

  logic clk_i;
  logic rst_ni;

  prm_in_if  in_if ();
  prm_out_if out_if ();

  palette_colour_remap_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // own copy of the color table
  rgba_t source_tab [TABLE_ENTRIES];
  rgba_t repl_tab [TABLE_ENTRIES];

  remap_result_t remap_expect_q [$];
  remap_result_t head_res;
  int unsigned   mismatch_count = 0;
  int unsigned   in_idle_pct = 0;
  int unsigned   out_stall_pct = 0;
  int unsigned   hold_left = 0;
  int unsigned   quiet_cycles = 0;
  logic          hold_request = 1'b0;

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // table update and expected pixel for one accepted beat
  function automatic void remap_beat(op_e op, logic [IDX_W-1:0] idx, rgba_t colour);
    remap_result_t res;
    if (op == OP_WR_SOURCE || op == OP_WR_REPL) begin
      if (idx < TABLE_ENTRIES) begin
        if (op == OP_WR_SOURCE) source_tab[idx] = colour;
        else repl_tab[idx] = colour;
      end
    end else if (op == OP_PIXEL) begin
      res.pix = colour;
      res.replaced = 1'b0;
      res.hit = '0;
      for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
        if (source_tab[i] != repl_tab[i] && source_tab[i] == colour) begin
          res.pix.r = repl_tab[i].r;
          res.pix.g = repl_tab[i].g;
          res.pix.b = repl_tab[i].b;
          res.replaced = 1'b1;
          res.hit = i[IDX_W-1:0];
          break;
        end
      end
      remap_expect_q.push_back(res);
    end
  endfunction

  // half the time one of four shared colors so that sources collide
  function automatic rgba_t pick_colour();
    rgba_t c;
    if ($urandom_range(0, 1) == 0) begin
      c = $urandom;
    end else begin
      case ($urandom_range(0, 3))
        0: c = '0;
        1: c = '1;
        2: c = 32'h80402010;
        default: c = 32'h7F7F7F7F;
      endcase
    end
    return c;
  endfunction

  task automatic send_beat(input op_e op, input logic [IDX_W-1:0] idx, input rgba_t colour);
    logic rdy;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.op          <= op;
    in_if.entry_index <= idx;
    in_if.red_in      <= colour.r;
    in_if.green_in    <= colour.g;
    in_if.blue_in     <= colour.b;
    in_if.alpha_in    <= colour.a;
    // ready is stable from the falling edge to the next rising edge
    do begin
      @(negedge clk_i);
      rdy = in_if.ready;
      @(posedge clk_i);
    end while (rdy !== 1'b1);
    remap_beat(op, idx, colour);
  endtask

  task automatic send_random_beat();
    int unsigned      roll;
    logic [IDX_W-1:0] idx;
    rgba_t            colour;
    roll = $urandom_range(0, 99);
    idx = IDX_W'($urandom_range(0, TABLE_ENTRIES - 1));
    colour = pick_colour();
    if (roll < 12) begin
      send_beat(OP_WR_SOURCE, idx, colour);
    end else if (roll < 24) begin
      // sometimes equal to the source, which turns the entry off
      if ($urandom_range(0, 3) == 0) colour = source_tab[idx];
      send_beat(OP_WR_REPL, idx, colour);
    end else if (roll < 27) begin
      send_beat(OP_UNUSED, idx, colour);
    end else begin
      if ($urandom_range(0, 99) < 60) begin
        colour = source_tab[IDX_W'($urandom_range(0, TABLE_ENTRIES - 1))];
        if ($urandom_range(0, 3) == 0) colour.a = CH_W'($urandom);
      end
      send_beat(OP_PIXEL, IDX_W'($urandom), colour);
    end
  endtask

  task automatic wait_drained();
    while (remap_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_table();
    send_beat(OP_PIXEL, 4'h0, 32'h00000000);
    send_beat(OP_PIXEL, 4'hF, 32'hFFFFFFFF);
  endtask

  task automatic test_single_match();
    send_beat(OP_WR_SOURCE, 4'h0, 32'hFFFFFFFF);
    send_beat(OP_WR_REPL, 4'h0, 32'h00000000);
    send_beat(OP_PIXEL, 4'h0, 32'hFFFFFFFF);
    send_beat(OP_PIXEL, 4'h0, 32'hFFFFFF00);
  endtask

  task automatic test_inactive_entries();
    send_beat(OP_WR_SOURCE, 4'h5, 32'h11223344);
    send_beat(OP_WR_REPL, 4'h5, 32'h11223344);
    send_beat(OP_PIXEL, 4'h0, 32'h11223344);
    // alpha-only difference still makes the entry active
    send_beat(OP_WR_REPL, 4'h5, 32'h11223345);
    send_beat(OP_PIXEL, 4'h0, 32'h11223344);
  endtask

  task automatic test_lowest_entry_wins();
    send_beat(OP_WR_SOURCE, 4'hF, 32'hA5A5A5A5);
    send_beat(OP_WR_REPL, 4'hF, 32'h5A5A5A5A);
    send_beat(OP_PIXEL, 4'h0, 32'hA5A5A5A5);
    send_beat(OP_WR_SOURCE, 4'h3, 32'hA5A5A5A5);
    send_beat(OP_WR_REPL, 4'h3, 32'h0F0F0F0F);
    send_beat(OP_PIXEL, 4'h0, 32'hA5A5A5A5);
  endtask

  task automatic test_unused_op();
    send_beat(OP_UNUSED, 4'h3, 32'hA5A5A5A5);
    send_beat(OP_PIXEL, 4'h0, 32'hA5A5A5A5);
  endtask

  task automatic test_random_traffic();
    int unsigned idle_sets [4][2] = '{'{0, 0}, '{76, 0}, '{0, 76}, '{33, 33}};
    for (int p = 0; p < 4; p++) begin
      in_idle_pct = idle_sets[p][0];
      out_stall_pct = idle_sets[p][1];
      repeat (160) send_random_beat();
    end
  endtask

  task automatic test_output_backpressure();
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_request = 1'b1;
    repeat (60) send_random_beat();
  endtask

  task automatic test_drain_pause();
    in_idle_pct = 33;
    out_stall_pct = 33;
    repeat (25) send_random_beat();
    in_if.valid <= 1'b0;
    wait_drained();
    @(posedge clk_i);
    repeat (25) send_random_beat();
  endtask

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= out_stall_pct);
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (remap_expect_q.size() == 0) begin
        $error("pixel beat with no expectation: rgba %02h%02h%02h%02h", out_if.red_out,
               out_if.green_out, out_if.blue_out, out_if.alpha_out);
        mismatch_count++;
      end else begin
        head_res = remap_expect_q.pop_front();
        if (out_if.red_out !== head_res.pix.r) begin
          $error("red_out: expected %0h, got %0h", head_res.pix.r, out_if.red_out);
          mismatch_count++;
        end
        if (out_if.green_out !== head_res.pix.g) begin
          $error("green_out: expected %0h, got %0h", head_res.pix.g, out_if.green_out);
          mismatch_count++;
        end
        if (out_if.blue_out !== head_res.pix.b) begin
          $error("blue_out: expected %0h, got %0h", head_res.pix.b, out_if.blue_out);
          mismatch_count++;
        end
        if (out_if.alpha_out !== head_res.pix.a) begin
          $error("alpha_out: expected %0h, got %0h", head_res.pix.a, out_if.alpha_out);
          mismatch_count++;
        end
        if (out_if.was_replaced !== head_res.replaced) begin
          $error("was_replaced: expected %0h, got %0h", head_res.replaced,
                 out_if.was_replaced);
          mismatch_count++;
        end
        if (out_if.hit_entry !== head_res.hit) begin
          $error("hit_entry: expected %0h, got %0h", head_res.hit, out_if.hit_entry);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk_i);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = OP_PIXEL;
    in_if.entry_index = '0;
    in_if.red_in = '0;
    in_if.green_in = '0;
    in_if.blue_in = '0;
    in_if.alpha_in = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      source_tab[i] = '0;
      repl_tab[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_single_match();
    test_inactive_entries();
    test_lowest_entry_wins();
    test_unused_op();
    test_random_traffic();
    test_output_backpressure();
    test_drain_pause();

    in_if.valid <= 1'b0;
    wait_drained();
    repeat (2 * CHAIN_LATENCY) @(posedge clk_i);
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
